// File: src/mzo_pkg.sv
// mzo_pkg: shared types, constants and codes for the mirrored zigzag order table
// used by the top, mzo_ctrl and mzo_datapath, no dependencies
`default_nettype none
package mzo_pkg;

  localparam int MAX_COLUMNS = 32;
  localparam int MAX_ROWS    = 32;
  localparam int TABLE_DEPTH = MAX_COLUMNS * MAX_ROWS;

  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int X_W     = $clog2(MAX_COLUMNS);
  localparam int Y_W     = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_W   = $clog2(MAX_ROWS + 1);
  localparam int HC_W    = 5;
  localparam int RC_W    = 6;
  localparam int HALF_W  = $clog2(TABLE_DEPTH / 2 + 1);
  localparam int ENTRY_W = 9;
  localparam int VALUE_W = 11;
  localparam int POS_W   = HALF_W + 2;

  localparam int IN_DATA_W  = ((X_W + Y_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((VALUE_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef logic signed [POS_W-1:0] pos_t;
  localparam pos_t POS_ZERO = 0;
  localparam pos_t POS_ONE  = 1;
  localparam pos_t POS_TWO  = 2;

  typedef enum logic {
    ACT_BUILD = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_COLUMNS  = 2'd0,
    REG_ROW_COUNT     = 2'd1,
    REG_REVERSE_ANGLE = 2'd2,
    REG_REVERSE_ORDER = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_CELL,
    ST_MIRROR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start_build;
    logic start_query;
    logic wr_cell;
    logic wr_mirror;
    logic load_query;
    logic load_build;
  } mzo_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } mzo_status_t;

endpackage
`default_nettype wire

// File: src/mirrored_zigzag_order_table_top.sv
// channel  dir  transaction contents
// in_      in   tuser: action; tdata: cell_x, cell_y
// out_     out  tuser: error; tdata: value
// cfg_     in   register index and write data, always ready
//
// query: accepted in ST_IDLE, which starts the table read; the result is loaded in ST_QUERY, then in_ is ready again
// build: each walk step writes the cell in ST_CELL, then its mirror in ST_MIRROR (one table write port)
// a held result in the output register does not block the next input transaction
// rst_n is synchronous; the order table is not cleared, only written by builds
// top level of the mirrored zigzag order table
// depends on mzo_pkg, mzo_ctrl, mzo_datapath
`default_nettype none
module mirrored_zigzag_order_table_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [mzo_pkg::IN_DATA_W-1:0]       in_tdata,   // cell_x, cell_y, zero pad
  input  wire logic                                in_tuser,   // action
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [mzo_pkg::OUT_DATA_W-1:0]           out_tdata,  // value, zero pad
  output logic                                     out_tuser,  // error
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mzo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mzo_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mzo_pkg::*;

  mzo_cmd_t           cmd;
  mzo_status_t        status;
  logic [VALUE_W-1:0] out_value;

  assign cfg_ready = 1'b1;

  mzo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (in_tuser),
    .status    (status),
    .in_ready  (in_tready),
    .cmd       (cmd)
  );

  mzo_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_x      (in_tdata[X_W-1:0]),
    .in_y      (in_tdata[X_W+Y_W-1:X_W]),
    .cmd       (cmd),
    .out_ready (out_tready),
    .status    (status),
    .out_valid (out_tvalid),
    .out_value (out_value),
    .out_error (out_tuser)
  );

  assign out_tdata = OUT_DATA_W'(out_value);

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while previous item still in progress");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("reset did not return block to idle");

  a_error_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("out of grid result carries nonzero value");

  a_build_never_done_early: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_build |-> status.walk_done)
    else $error("build result issued before walk finished");
`endif

endmodule
`default_nettype wire

// File: src/mzo_ram.sv
// mzo_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none
module mzo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: src/mzo_ctrl.sv
// mzo_ctrl: sequencer for build walk and query read
// depends on mzo_pkg
`default_nettype none
module mzo_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_action,
  input  wire mzo_pkg::mzo_status_t status,
  output logic                      in_ready,
  output mzo_pkg::mzo_cmd_t         cmd
);
  import mzo_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_QUERY) ? ST_QUERY : ST_CELL;
        end
      end
      ST_QUERY: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      ST_CELL: begin
        state_nxt = status.walk_done ? ST_DONE : ST_MIRROR;
      end
      ST_MIRROR: state_nxt = ST_CELL;
      ST_DONE: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready        = 1'b1;
        cmd.start_query = in_valid && (in_action == ACT_QUERY);
        cmd.start_build = in_valid && (in_action == ACT_BUILD);
      end
      ST_QUERY:  cmd.load_query = status.out_free;
      ST_CELL:   cmd.wr_cell    = !status.walk_done;
      ST_MIRROR: cmd.wr_mirror  = 1'b1;
      ST_DONE:   cmd.load_build = status.out_free;
      default: begin
        in_ready = 1'b0;
        cmd      = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/mzo_datapath.sv
// mzo_datapath: config registers, zigzag walk position, table ram and result register
// depends on mzo_pkg and mzo_ram
`default_nettype none
module mzo_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  input  wire logic [mzo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mzo_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [mzo_pkg::X_W-1:0]          in_x,
  input  wire logic [mzo_pkg::Y_W-1:0]          in_y,
  input  wire mzo_pkg::mzo_cmd_t                cmd,
  input  wire logic                             out_ready,
  output mzo_pkg::mzo_status_t                  status,
  output logic                                  out_valid,
  output logic [mzo_pkg::VALUE_W-1:0]           out_value,
  output logic                                  out_error
);
  import mzo_pkg::*;

  // configuration
  logic [HC_W-1:0] half_cols_r;
  logic [RC_W-1:0] row_count_r;
  logic            rev_angle_r;
  logic            rev_order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_cols_r <= HC_W'(4);
      row_count_r <= RC_W'(8);
      rev_angle_r <= 1'b0;
      rev_order_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_HALF_COLUMNS:  half_cols_r <= cfg_data[HC_W-1:0];
        REG_ROW_COUNT:     row_count_r <= cfg_data[RC_W-1:0];
        REG_REVERSE_ANGLE: rev_angle_r <= cfg_data[0];
        REG_REVERSE_ORDER: rev_order_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective grid size, saturated to the supported range
  logic [COL_W-2:0]   half_eff;
  logic [COL_W-1:0]   cols;
  logic [ROW_W-1:0]   rows;
  logic [HALF_W-1:0]  half;
  logic [VALUE_W-1:0] cells;
  pos_t               cols_s, rows_s;

  always_comb begin
    if (half_cols_r == '0) begin
      half_eff = (COL_W-1)'(1);
    end else if (COL_W'(half_cols_r) > COL_W'(MAX_COLUMNS / 2)) begin
      half_eff = (COL_W-1)'(MAX_COLUMNS / 2);
    end else begin
      half_eff = (COL_W-1)'(half_cols_r);
    end
    if (row_count_r == '0) begin
      rows = ROW_W'(1);
    end else if ((RC_W + 1)'(row_count_r) > (RC_W + 1)'(MAX_ROWS)) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = ROW_W'(row_count_r);
    end
    cols   = {half_eff, 1'b0};
    half   = HALF_W'(half_eff * rows);
    cells  = VALUE_W'({half, 1'b0});
    cols_s = pos_t'({{(POS_W-COL_W){1'b0}}, cols});
    rows_s = pos_t'({{(POS_W-ROW_W){1'b0}}, rows});
  end

  // walk state
  pos_t              i_r, i_nxt, j_r, j_nxt;
  logic              dir_r, dir_nxt;
  logic [HALF_W-1:0] idx_r, idx_nxt;
  pos_t              step_i, step_j;
  logic              in_grid;

  assign in_grid = (i_r >= POS_ZERO) && (i_r < cols_s) && (j_r >= POS_ZERO) && (j_r < rows_s);

  always_comb begin
    i_nxt   = i_r;
    j_nxt   = j_r;
    dir_nxt = dir_r;
    idx_nxt = idx_r;
    step_i  = dir_r ? i_r - POS_ONE : i_r + POS_ONE;
    step_j  = dir_r ? j_r + POS_ONE : j_r - POS_ONE;
    if (cmd.start_build) begin
      i_nxt   = POS_ZERO;
      j_nxt   = POS_ZERO;
      dir_nxt = 1'b0;
      idx_nxt = '0;
    end else if (cmd.wr_mirror) begin
      idx_nxt = idx_r + HALF_W'(1);
      i_nxt   = step_i;
      j_nxt   = step_j;
      // turn back at an edge and reverse direction
      if (step_i < POS_ZERO || step_j < POS_ZERO || step_i >= cols_s || step_j >= rows_s) begin
        if (i_nxt >= cols_s) begin
          i_nxt = cols_s - POS_ONE;
          j_nxt = j_nxt + POS_TWO;
        end
        if (j_nxt >= rows_s) begin
          j_nxt = rows_s - POS_ONE;
          i_nxt = i_nxt + POS_TWO;
        end
        if (i_nxt < POS_ZERO) i_nxt = POS_ZERO;
        if (j_nxt < POS_ZERO) j_nxt = POS_ZERO;
        dir_nxt = !dir_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    dir_r <= dir_nxt;
    idx_r <= idx_nxt;
  end

  // table write: cell on one cycle, point-mirrored cell on the next
  logic [X_W-1:0]     wx;
  logic [Y_W-1:0]     wy;
  logic [COL_W-1:0]   mx_full;
  logic [ROW_W-1:0]   my_full;
  logic [ADDR_W:0]    waddr_full;
  logic [ADDR_W-1:0]  waddr;
  logic               we;

  always_comb begin
    mx_full    = cols - COL_W'(1) - COL_W'(i_r[X_W-1:0]);
    my_full    = rows - ROW_W'(1) - ROW_W'(j_r[Y_W-1:0]);
    wx         = cmd.wr_mirror ? mx_full[X_W-1:0] : i_r[X_W-1:0];
    wy         = cmd.wr_mirror ? my_full[Y_W-1:0] : j_r[Y_W-1:0];
    waddr_full = (ADDR_W + 1)'(wx * rows) + (ADDR_W + 1)'(wy);
    waddr      = waddr_full[ADDR_W-1:0];
    we         = (cmd.wr_cell || cmd.wr_mirror) && in_grid;
  end

  // query read address, row mirrored on request
  logic [ROW_W-1:0]  ry_full;
  logic [Y_W-1:0]    ry;
  logic [ADDR_W:0]   raddr_full;
  logic [ADDR_W-1:0] raddr;
  logic              q_out_of_grid;

  always_comb begin
    ry_full       = rev_angle_r ? rows - ROW_W'(1) - ROW_W'(in_y) : ROW_W'(in_y);
    ry            = ry_full[Y_W-1:0];
    raddr_full    = (ADDR_W + 1)'(in_x * rows) + (ADDR_W + 1)'(ry);
    raddr         = raddr_full[ADDR_W-1:0];
    q_out_of_grid = (COL_W'(in_x) >= cols) || (ROW_W'(in_y) >= rows);
  end

  logic [ENTRY_W-1:0] rdata;

  mzo_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (idx_r[ENTRY_W-1:0]),
    .re    (cmd.start_query),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic q_err_r;

  always_ff @(posedge clk) begin
    if (cmd.start_query) begin
      q_err_r <= q_out_of_grid;
    end
  end

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic               out_error_r, out_error_nxt;
  logic [VALUE_W-1:0] q_value;

  always_comb begin
    if (q_err_r) begin
      q_value = '0;
    end else if (rev_order_r) begin
      q_value = VALUE_W'(rdata);
    end else begin
      q_value = VALUE_W'(half) - VALUE_W'(rdata) - VALUE_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_error_nxt = out_error_r;
    if (cmd.load_query) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = q_value;
      out_error_nxt = q_err_r;
    end else if (cmd.load_build) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = cells;
      out_error_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_error_r <= out_error_nxt;
  end

  assign status.walk_done = (idx_r >= half);
  assign status.out_free  = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_error        = out_error_r;

endmodule
`default_nettype wire

// File: verif/mirrored_zigzag_order_table_top_tb.sv
// testbench for the mirrored zigzag order table: directed, back-pressure and random phases
// predicts every result in-house and checks each out_ transaction in order
// depends on mzo_pkg and mirrored_zigzag_order_table_top
`timescale 1ns / 1ps
module mirrored_zigzag_order_table_top_tb;
  import mzo_pkg::*;

  localparam int ITEM_TARGET    = 1850;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int DRAIN_CYCLES   = 50;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
  } order_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // in-house copy of the block state
  logic [ENTRY_W-1:0] index_table [TABLE_DEPTH];
  bit                 entry_valid [TABLE_DEPTH];
  logic [HC_W-1:0]    hc_setting   = HC_W'(4);
  logic [RC_W-1:0]    rows_setting = RC_W'(8);
  bit                 mirror_rows  = 1'b0;
  bit                 keep_order   = 1'b0;

  order_result_t pending_results [$];
  int            fail_count  = 0;
  int            items_sent  = 0;
  int            burst_left  = 0;
  int            quiet_cycles = 0;
  bit            hold_req    = 1'b0;
  bit            hold_active = 1'b0;

  mirrored_zigzag_order_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int grid_cols();
    int h;
    h = int'(hc_setting);
    if (h < 1) h = 1;
    if (h > MAX_COLUMNS / 2) h = MAX_COLUMNS / 2;
    return 2 * h;
  endfunction

  function automatic int grid_rows();
    int r;
    r = int'(rows_setting);
    if (r < 1) r = 1;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  function automatic void store_index(int addr, int idx);
    if (addr >= 0 && addr < TABLE_DEPTH) begin
      index_table[addr] = idx[ENTRY_W-1:0];
      entry_valid[addr] = 1'b1;
    end
  endfunction

  // diagonal walk, each step also writes the point-mirrored cell
  function automatic void walk_zigzag(int cols, int rows);
    int half, idx, i, j, dx, dy;
    half = cols * rows / 2;
    idx  = 0;
    i    = 0;
    j    = 0;
    dx   = 1;
    dy   = -1;
    while (idx < half) begin
      if (i >= 0 && i < cols && j >= 0 && j < rows) begin
        store_index(i * rows + j, idx);
        store_index((cols - i - 1) * rows + (rows - j - 1), idx);
      end
      idx++;
      i += dx;
      j += dy;
      if (i < 0 || j < 0 || i >= cols || j >= rows) begin
        if (i >= cols) begin
          i = cols - 1;
          j += 2;
        end
        if (j >= rows) begin
          j = rows - 1;
          i += 2;
        end
        if (i < 0) i = 0;
        if (j < 0) j = 0;
        dx = -dx;
        dy = -dy;
      end
    end
  endfunction

  function automatic order_result_t lookup_order(int x, int y);
    order_result_t res;
    int cols, rows, yy, addr, stored, v;
    cols = grid_cols();
    rows = grid_rows();
    res  = '0;
    if (x >= cols || y >= rows) begin
      res.error = 1'b1;
      return res;
    end
    yy     = mirror_rows ? rows - y - 1 : y;
    addr   = x * rows + yy;
    stored = entry_valid[addr] ? int'(index_table[addr]) : 0;
    v      = keep_order ? stored : cols * rows / 2 - stored - 1;
    res.value = v[VALUE_W-1:0];
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic int next_send_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
    return random_gap();
  endfunction

  task automatic send_item(action_t act, logic [X_W-1:0] x, logic [Y_W-1:0] y);
    order_result_t want;
    int gap;
    gap = next_send_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_DATA_W - X_W - Y_W){1'b0}}, y, x};
    do @(posedge clk); while (!in_tready);
    if (act == ACT_BUILD) begin
      walk_zigzag(grid_cols(), grid_rows());
      want.value = VALUE_W'(grid_cols() * grid_rows());
      want.error = 1'b0;
    end else begin
      want = lookup_order(int'(x), int'(y));
    end
    pending_results.push_back(want);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HALF_COLUMNS:  hc_setting   = val[HC_W-1:0];
      REG_ROW_COUNT:     rows_setting = val[RC_W-1:0];
      REG_REVERSE_ANGLE: mirror_rows  = val[0];
      REG_REVERSE_ORDER: keep_order   = val[0];
      default: ;
    endcase
  endtask

  // valid stays high across the four writes and drops after the last
  task automatic set_grid(int hc, int rows, bit angle, bit order);
    wait_idle();
    write_reg(REG_HALF_COLUMNS, hc);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_REVERSE_ANGLE, angle);
    write_reg(REG_REVERSE_ORDER, order);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_query(bit in_grid);
    int cols, rows, yy, tries;
    bit full, found;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    cols  = grid_cols();
    rows  = grid_rows();
    full  = (cols == MAX_COLUMNS) && (rows == MAX_ROWS);
    found = 1'b0;
    x     = '0;
    y     = '0;
    if (in_grid || full) begin
      // only cells that some build has written
      for (tries = 0; tries < 8 && !found; tries++) begin
        x     = X_W'($urandom_range(0, cols - 1));
        y     = Y_W'($urandom_range(0, rows - 1));
        yy    = mirror_rows ? rows - 1 - int'(y) : int'(y);
        found = entry_valid[int'(x) * rows + yy];
      end
    end
    if (found) begin
      send_item(ACT_QUERY, x, y);
    end else if (!full) begin
      if (rows == MAX_ROWS || (cols < MAX_COLUMNS && $urandom_range(0, 1) == 1)) begin
        x = X_W'($urandom_range(cols, MAX_COLUMNS - 1));
        y = Y_W'($urandom_range(0, MAX_ROWS - 1));
      end else begin
        x = X_W'($urandom_range(0, MAX_COLUMNS - 1));
        y = Y_W'($urandom_range(rows, MAX_ROWS - 1));
      end
      send_item(ACT_QUERY, x, y);
    end else begin
      send_item(ACT_BUILD, X_W'($urandom_range(0, 31)), Y_W'($urandom_range(0, 31)));
    end
  endtask

  task automatic test_reset_defaults();
    send_item(ACT_BUILD, 5'd31, 5'd31);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd7, 5'd7);
    send_item(ACT_QUERY, 5'd5, 5'd2);
    send_item(ACT_QUERY, 5'd8, 5'd0);
    send_item(ACT_QUERY, 5'd0, 5'd8);
    send_item(ACT_QUERY, 5'd31, 5'd31);
    set_grid(4, 8, 1'b1, 1'b1);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd7, 5'd7);
    send_item(ACT_QUERY, 5'd3, 5'd5);
  endtask

  task automatic test_grid_extremes();
    // zero sizes act as the smallest grid
    set_grid(0, 0, 1'b0, 1'b1);
    send_item(ACT_BUILD, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd1, 5'd0);
    send_item(ACT_QUERY, 5'd0, 5'd1);
    // oversized values saturate to the full grid
    set_grid(31, 63, 1'b1, 1'b0);
    send_item(ACT_BUILD, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd31, 5'd31);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd16, 5'd15);
    set_grid(16, 32, 1'b0, 1'b1);
    send_item(ACT_QUERY, 5'd31, 5'd0);
    send_item(ACT_QUERY, 5'd0, 5'd31);
    // stale entries from the big grid, order flip wraps
    set_grid(1, 1, 1'b0, 1'b0);
    send_item(ACT_QUERY, 5'd0, 5'd0);
    send_item(ACT_QUERY, 5'd1, 5'd0);
    send_item(ACT_QUERY, 5'd2, 5'd0);
  endtask

  task automatic test_backpressure();
    set_grid(2, 4, 1'b0, 1'b1);
    send_item(ACT_BUILD, 5'd0, 5'd0);
    hold_req = 1'b1;
    wait (hold_active);
    burst_left = 60;
    repeat (60) send_random_query(1'b1);
  endtask

  task automatic test_random_phases();
    int hc, rows, queries, r;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      hc = (r < 8) ? $urandom_range(1, 4) : (r == 8) ? 0 : $urandom_range(5, 31);
      r = $urandom_range(0, 9);
      rows = (r < 8) ? $urandom_range(1, 8) : (r == 8) ? 0 : $urandom_range(9, 63);
      set_grid(hc, rows, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      // now and then keep the old table and read stale entries
      if ($urandom_range(0, 3) != 0)
        send_item(ACT_BUILD, X_W'($urandom_range(0, 31)), Y_W'($urandom_range(0, 31)));
      queries = $urandom_range(15, 60);
      repeat (queries) begin
        r = $urandom_range(0, 99);
        if (r < 3)
          send_item(ACT_BUILD, X_W'($urandom_range(0, 31)), Y_W'($urandom_range(0, 31)));
        else
          send_random_query(r < 80);
      end
    end
  endtask

  task automatic report_mismatch(string what, int want, int got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : result_check
    order_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("transaction with nothing pending, value", -1,
                        int'(out_tdata[VALUE_W-1:0]));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[VALUE_W-1:0] !== want.value)
          report_mismatch("value", int'(want.value), int'(out_tdata[VALUE_W-1:0]));
        if (out_tuser !== want.error)
          report_mismatch("error flag", int'(want.error), int'(out_tuser));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : receiver
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req    = 1'b0;
        out_tready <= 1'b0;
        hold_active = 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_active = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        stall = random_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin : main
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = ACT_BUILD;
    cfg_valid = 1'b0;
    cfg_index = REG_HALF_COLUMNS;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_grid_extremes();
    test_backpressure();
    test_random_phases();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
